[rtl/stp_pkg.sv]
package stp_pkg;

  localparam int unsigned TIMER_WIDTH      = 32;
  localparam int unsigned COUNT_WIDTH      = 32;
  localparam int unsigned CHAN_WIDTH       = 3;
  localparam int unsigned NUM_CHANNELS_DEF = 7;

  localparam int unsigned IN_TDATA_WIDTH  = 72;
  localparam int unsigned OUT_TDATA_WIDTH = 136;

  localparam logic [CHAN_WIDTH-1:0]  ADC_CHANNEL  = 3'd0;
  localparam logic [CHAN_WIDTH-1:0]  SLOT_CHANNEL = 3'd6;
  localparam logic [TIMER_WIDTH-1:0] BUDGET_RESET = 32'hFFFF_FFFF;

  typedef enum logic {
    OP_BEGIN = 1'b0,
    OP_END   = 1'b1
  } stp_op_e;

  typedef struct packed {
    stp_op_e                 opcode;
    logic [CHAN_WIDTH-1:0]   channel;
    logic [TIMER_WIDTH-1:0]  timestamp;
    logic [COUNT_WIDTH-1:0]  clear_sequence;
  } stp_event_t;

  typedef struct packed {
    logic [CHAN_WIDTH-1:0]   out_channel;
    logic [TIMER_WIDTH-1:0]  last_ticks;
    logic [TIMER_WIDTH-1:0]  max_ticks;
    logic [COUNT_WIDTH-1:0]  end_count;
    logic [COUNT_WIDTH-1:0]  over_budget_count;
    logic                    over_budget;
  } stp_result_t;

endpackage

[rtl/stp_in_stage.sv]
module stp_in_stage (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [stp_pkg::IN_TDATA_WIDTH-1:0]    s_axis_tdata,
  input  logic                                  s_axis_tuser,
  input  logic                                  advance_i,
  output logic                                  vld_o,
  output stp_pkg::stp_event_t                   ev_o
);
  import stp_pkg::*;

  logic       vld_q, vld_d;
  stp_event_t ev_q, ev_d;
  logic       take;

  assign s_axis_tready = !vld_q || advance_i;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    vld_d = vld_q;
    ev_d  = ev_q;
    if (advance_i) begin
      vld_d = 1'b0;
    end
    if (take) begin
      vld_d             = 1'b1;
      ev_d.opcode       = stp_op_e'(s_axis_tuser);
      ev_d.channel      = s_axis_tdata[CHAN_WIDTH-1:0];
      ev_d.timestamp    = s_axis_tdata[CHAN_WIDTH +: TIMER_WIDTH];
      ev_d.clear_sequence = s_axis_tdata[CHAN_WIDTH+TIMER_WIDTH +: COUNT_WIDTH];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q <= ev_d;
  end

  assign vld_o = vld_q;
  assign ev_o  = ev_q;

endmodule

[rtl/stp_stats.sv]
module stp_stats #(
  parameter int unsigned NUM_CHANNELS = stp_pkg::NUM_CHANNELS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [stp_pkg::TIMER_WIDTH-1:0]    cfg_wdata_i,
  input  logic                               vld_i,
  input  stp_pkg::stp_event_t                ev_i,
  input  logic                               update_i,
  output logic                               has_result_o,
  output stp_pkg::stp_result_t               res_o
);
  import stp_pkg::*;

  localparam int unsigned IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [TIMER_WIDTH-1:0] budget_q;
  logic [TIMER_WIDTH-1:0] start_q [NUM_CHANNELS];
  logic [TIMER_WIDTH-1:0] max_q   [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0] adc_cnt_q, slot_cnt_q, miss_q, seen_seq_q;

  logic [IdxW-1:0]        idx;
  logic                   in_range, is_adc, is_slot, is_end, over;
  logic                   do_clear;
  logic [TIMER_WIDTH-1:0] start_rd, max_rd, elapsed, max_new;
  logic [COUNT_WIDTH-1:0] adc_cnt_d, slot_cnt_d, miss_d;

  assign idx      = IdxW'(ev_i.channel);
  assign in_range = int'(ev_i.channel) < NUM_CHANNELS;
  assign is_adc   = ev_i.channel == ADC_CHANNEL;
  assign is_slot  = ev_i.channel == SLOT_CHANNEL;
  assign is_end   = ev_i.opcode == OP_END;
  assign do_clear = !is_end && is_adc && (ev_i.clear_sequence != seen_seq_q);

  always_comb begin
    start_rd = '0;
    max_rd   = '0;
    if (in_range) begin
      start_rd = start_q[idx];
      max_rd   = max_q[idx];
    end
  end

  assign elapsed    = start_rd - ev_i.timestamp;
  assign max_new    = (elapsed > max_rd) ? elapsed : max_rd;
  assign over       = is_adc && (elapsed > budget_q);
  assign adc_cnt_d  = adc_cnt_q + COUNT_WIDTH'(1);
  assign slot_cnt_d = slot_cnt_q + COUNT_WIDTH'(1);
  assign miss_d     = miss_q + COUNT_WIDTH'(over);

  assign has_result_o = vld_i && in_range && is_end;

  always_comb begin
    res_o.out_channel       = ev_i.channel;
    res_o.last_ticks        = elapsed;
    res_o.max_ticks         = max_new;
    res_o.over_budget       = over;
    res_o.end_count         = '0;
    res_o.over_budget_count = '0;
    if (is_adc) begin
      res_o.end_count         = adc_cnt_d;
      res_o.over_budget_count = miss_d;
    end else if (is_slot) begin
      res_o.end_count = slot_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q   <= BUDGET_RESET;
      adc_cnt_q  <= '0;
      slot_cnt_q <= '0;
      miss_q     <= '0;
      seen_seq_q <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        start_q[i] <= '0;
        max_q[i]   <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        budget_q <= cfg_wdata_i;
      end
      if (update_i && in_range) begin
        if (!is_end) begin
          if (do_clear) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
              max_q[i] <= '0;
            end
            miss_q     <= '0;
            seen_seq_q <= ev_i.clear_sequence;
          end
          start_q[idx] <= ev_i.timestamp;
        end else begin
          max_q[idx] <= max_new;
          if (is_adc) begin
            adc_cnt_q <= adc_cnt_d;
            miss_q    <= miss_d;
          end else if (is_slot) begin
            slot_cnt_q <= slot_cnt_d;
          end
        end
      end
    end
  end

endmodule

[rtl/stp_out_stage.sv]
module stp_out_stage (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  load_i,
  input  stp_pkg::stp_result_t                  res_i,
  output logic                                  free_o,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [stp_pkg::OUT_TDATA_WIDTH-1:0]   m_axis_tdata,
  output logic                                  m_axis_tuser
);
  import stp_pkg::*;

  localparam int unsigned PackW = CHAN_WIDTH + 2 * TIMER_WIDTH + 2 * COUNT_WIDTH;

  logic        vld_q, vld_d;
  stp_result_t res_q;

  assign free_o = !vld_q || m_axis_tready;

  always_comb begin
    vld_d = vld_q;
    if (m_axis_tready) begin
      vld_d = 1'b0;
    end
    if (load_i) begin
      vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tuser  = res_q.over_budget;
  assign m_axis_tdata  = {{(OUT_TDATA_WIDTH - PackW){1'b0}},
                          res_q.over_budget_count, res_q.end_count,
                          res_q.max_ticks, res_q.last_ticks, res_q.out_channel};

endmodule

[rtl/section_timing_profiler_core.sv]
// Section timing profiler.
// Input stream s_axis: one word per begin or end marker of a code section.
// Output stream m_axis: one word per end marker on a valid channel, carrying
// the elapsed ticks, the channel maximum and the channel 0 / channel 6 counts.
// Begin markers and markers on a channel past the last one give no word.
// cfg_we_i with cfg_wdata_i loads the channel 0 budget in ticks; write it
// only while no marker is in flight.
// A word accepted into the input register is evaluated and its result loaded
// into the output register, which drives tvalid. Throughput is one word per
// cycle while the receiver does not stall, set by the single state read,
// subtract and compare between the input and output registers.
// If the receiver stalls, the result holds in the output register; begin
// markers keep flowing, and an end marker on a valid channel waits in the input
// register until the output register frees, with s_axis_tready low for as long as it waits.
// Reset clears all start times, maxima, counts and the seen clear sequence,
// and sets the budget to all ones.
module section_timing_profiler_core #(
  parameter int unsigned NUM_CHANNELS = stp_pkg::NUM_CHANNELS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [stp_pkg::TIMER_WIDTH-1:0]       cfg_wdata_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // channel, timestamp, clear_sequence, zero fill
  input  logic [stp_pkg::IN_TDATA_WIDTH-1:0]    s_axis_tdata,
  // opcode
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // out_channel, last_ticks, max_ticks, end_count, over_budget_count, zero fill
  output logic [stp_pkg::OUT_TDATA_WIDTH-1:0]   m_axis_tdata,
  // over_budget
  output logic                                  m_axis_tuser
);
  import stp_pkg::*;

  logic        ev_vld, has_result, out_free, advance;
  stp_event_t  ev;
  stp_result_t res;

  assign advance = ev_vld && (!has_result || out_free);

  stp_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .advance_i     (advance),
    .vld_o         (ev_vld),
    .ev_o          (ev)
  );

  stp_stats #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_stats (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .vld_i        (ev_vld),
    .ev_i         (ev),
    .update_i     (advance),
    .has_result_o (has_result),
    .res_o        (res)
  );

  stp_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance && has_result),
    .res_i         (res),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

[rtl/stp_checker.sv]
module stp_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  m_axis_tvalid,
  input logic                                  m_axis_tready,
  input logic [stp_pkg::OUT_TDATA_WIDTH-1:0]   m_axis_tdata,
  input logic                                  m_axis_tuser
);
  import stp_pkg::*;

  logic [CHAN_WIDTH-1:0]  o_chan;
  logic [TIMER_WIDTH-1:0] o_last, o_max;
  logic [COUNT_WIDTH-1:0] o_cnt, o_miss;

  assign o_chan = m_axis_tdata[CHAN_WIDTH-1:0];
  assign o_last = m_axis_tdata[CHAN_WIDTH +: TIMER_WIDTH];
  assign o_max  = m_axis_tdata[CHAN_WIDTH+TIMER_WIDTH +: TIMER_WIDTH];
  assign o_cnt  = m_axis_tdata[CHAN_WIDTH+2*TIMER_WIDTH +: COUNT_WIDTH];
  assign o_miss = m_axis_tdata[CHAN_WIDTH+2*TIMER_WIDTH+COUNT_WIDTH +: COUNT_WIDTH];

  a_hold_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_hold_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  a_over_adc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> o_chan == ADC_CHANNEL)
    else $error("over budget flag on a channel other than the adc channel");

  a_max_ge_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> o_max >= o_last)
    else $error("maximum below the last elapsed value");

  a_counts_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && o_chan != ADC_CHANNEL |-> o_miss == '0 &&
      (o_chan == SLOT_CHANNEL || o_cnt == '0))
    else $error("counts reported on a channel that has none");

endmodule

bind section_timing_profiler_core stp_checker u_stp_checker (.*);

[bench/section_timing_checker.sv]
module section_timing_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [stp_pkg::TIMER_WIDTH-1:0]     cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  // channel, timestamp, clear_sequence, zero fill
  input  logic [stp_pkg::IN_TDATA_WIDTH-1:0]  s_axis_tdata,
  // opcode
  input  logic                                s_axis_tuser,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_channel, last_ticks, max_ticks, end_count, over_budget_count, zero fill
  input  logic [stp_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,
  // over_budget
  input  logic                                m_axis_tuser,
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  markers_o,
  output int                                  results_o,
  output int                                  clears_o,
  output int                                  overs_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import stp_pkg::*;

  localparam int unsigned NUM_CH = NUM_CHANNELS_DEF;

  logic [TIMER_WIDTH-1:0] budget;
  logic [TIMER_WIDTH-1:0] start_stamp [NUM_CH];
  logic [TIMER_WIDTH-1:0] last_run    [NUM_CH];
  logic [TIMER_WIDTH-1:0] peak_run    [NUM_CH];
  logic [COUNT_WIDTH-1:0] adc_ends;
  logic [COUNT_WIDTH-1:0] slot_ends;
  logic [COUNT_WIDTH-1:0] budget_misses;
  logic [COUNT_WIDTH-1:0] seen_seq;

  stp_result_t pending_results [$];
  int mismatches;
  int markers;
  int results;
  int clears;
  int overs;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40)
      $display("result %0d: %s is %h, predicted %h", results, field, got, want);
    mismatches++;
  endtask

  task automatic profile_marker(input stp_op_e op, input logic [CHAN_WIDTH-1:0] ch,
                                input logic [TIMER_WIDTH-1:0] now,
                                input logic [COUNT_WIDTH-1:0] seq);
    logic [TIMER_WIDTH-1:0] run;
    stp_result_t res;
    if (ch < NUM_CH) begin
      if (op == OP_BEGIN) begin
        if (ch == ADC_CHANNEL && seq != seen_seq) begin
          for (int i = 0; i < NUM_CH; i++) peak_run[i] = '0;
          budget_misses = '0;
          seen_seq = seq;
          clears++;
        end
        start_stamp[ch] = now;
      end else begin
        run = start_stamp[ch] - now;
        last_run[ch] = run;
        if (run > peak_run[ch]) peak_run[ch] = run;
        res = '0;
        res.out_channel = ch;
        res.last_ticks = last_run[ch];
        res.max_ticks = peak_run[ch];
        if (ch == ADC_CHANNEL) begin
          adc_ends++;
          if (run > budget) begin
            budget_misses++;
            res.over_budget = 1'b1;
            overs++;
          end
          res.end_count = adc_ends;
          res.over_budget_count = budget_misses;
        end else if (ch == SLOT_CHANNEL) begin
          slot_ends++;
          res.end_count = slot_ends;
        end
        pending_results.push_back(res);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stp_result_t got;
    stp_result_t want;
    if (!rst_ni) begin
      budget = BUDGET_RESET;
      for (int i = 0; i < NUM_CH; i++) begin
        start_stamp[i] = '0;
        last_run[i] = '0;
        peak_run[i] = '0;
      end
      adc_ends = '0;
      slot_ends = '0;
      budget_misses = '0;
      seen_seq = '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.out_channel = m_axis_tdata[2:0];
        got.last_ticks = m_axis_tdata[34:3];
        got.max_ticks = m_axis_tdata[66:35];
        got.end_count = m_axis_tdata[98:67];
        got.over_budget_count = m_axis_tdata[130:99];
        got.over_budget = m_axis_tuser;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected word, last_ticks", got.last_ticks, '0);
        end else begin
          want = pending_results.pop_front();
          if (got.out_channel != want.out_channel)
            report_mismatch("out_channel", got.out_channel, want.out_channel);
          if (got.last_ticks != want.last_ticks)
            report_mismatch("last_ticks", got.last_ticks, want.last_ticks);
          if (got.max_ticks != want.max_ticks)
            report_mismatch("max_ticks", got.max_ticks, want.max_ticks);
          if (got.end_count != want.end_count)
            report_mismatch("end_count", got.end_count, want.end_count);
          if (got.over_budget_count != want.over_budget_count)
            report_mismatch("over_budget_count", got.over_budget_count,
                            want.over_budget_count);
          if (got.over_budget != want.over_budget)
            report_mismatch("over_budget", got.over_budget, want.over_budget);
        end
        results++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        profile_marker(stp_op_e'(s_axis_tuser), s_axis_tdata[2:0], s_axis_tdata[34:3],
                       s_axis_tdata[66:35]);
        markers++;
      end
      if (cfg_we_i) budget = cfg_wdata_i;
    end
    fail_count_o <= mismatches;
    pending_o <= pending_results.size();
    markers_o <= markers;
    results_o <= results;
    clears_o <= clears;
    overs_o <= overs;
  end

endmodule

[bench/section_timing_profiler_core_tb.sv]
module section_timing_profiler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS = 155;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [TIMER_WIDTH-1:0]     cfg_wdata_i = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata = '0;
  logic                       s_axis_tuser = 1'b0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata;
  logic                       m_axis_tuser;

  int fail_count;
  int pending;
  int markers;
  int results;
  int clears;
  int overs;

  logic burst = 1'b0;
  int   hold_left = 0;
  int   rx_pick;
  int   idle_cycles = 0;

  logic                   open_flag [8];
  logic [TIMER_WIDTH-1:0] open_ts   [8];
  logic [COUNT_WIDTH-1:0] cur_seq;
  logic [TIMER_WIDTH-1:0] budget_plan [6];

  section_timing_profiler_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  section_timing_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .markers_o     (markers),
    .results_o     (results),
    .clears_o      (clears),
    .overs_o       (overs)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: random ready runs and stalls, mostly short
  always @(posedge clk_i) begin
    if (burst) begin
      m_axis_tready <= 1'b1;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else begin
      rx_pick = $urandom_range(0, 99);
      m_axis_tready <= (rx_pick < 65);
      if (rx_pick < 65) hold_left <= $urandom_range(0, 7);
      else if (rx_pick < 95) hold_left <= $urandom_range(0, 2);
      else hold_left <= $urandom_range(10, 40);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (burst || p < 70) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_marker(input stp_op_e op, input logic [CHAN_WIDTH-1:0] ch,
                             input logic [TIMER_WIDTH-1:0] ts,
                             input logic [COUNT_WIDTH-1:0] seq);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {5'b0, seq, ts, ch};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  // drain, let the pipeline settle, then write the budget
  task automatic load_budget(input logic [TIMER_WIDTH-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_marker();
    logic [CHAN_WIDTH-1:0]  ch;
    logic [TIMER_WIDTH-1:0] d;
    logic [TIMER_WIDTH-1:0] ts;
    logic [COUNT_WIDTH-1:0] seq;
    stp_op_e                op;
    if ($urandom_range(0, 99) < 85) begin
      ch = CHAN_WIDTH'($urandom_range(0, NUM_CHANNELS_DEF - 1));
      seq = $urandom;
      if (open_flag[ch]) begin
        d = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000);
        send_marker(OP_END, ch, open_ts[ch] - d, seq);
        open_flag[ch] = 1'b0;
      end else begin
        ts = $urandom;
        if (ch == ADC_CHANNEL) begin
          if ($urandom_range(0, 9) == 0) cur_seq = $urandom;
          seq = cur_seq;
        end
        send_marker(OP_BEGIN, ch, ts, seq);
        open_flag[ch] = 1'b1;
        open_ts[ch] = ts;
      end
    end else begin
      op = stp_op_e'($urandom_range(0, 1));
      ch = CHAN_WIDTH'($urandom_range(0, 7));
      seq = $urandom;
      if (op == OP_BEGIN && ch == ADC_CHANNEL) cur_seq = seq;
      send_marker(op, ch, $urandom, seq);
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      open_flag[i] = 1'b0;
      open_ts[i] = '0;
    end
    cur_seq = '0;
    budget_plan[0] = BUDGET_RESET;
    budget_plan[1] = 32'd0;
    budget_plan[2] = 32'd1000;
    budget_plan[3] = $urandom_range(0, 2000);
    budget_plan[4] = 32'h7FFF_FFFF;
    budget_plan[5] = 32'hFFFF_FFFF;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed markers under the reset budget
    send_marker(OP_END,   3'd3, 32'h0000_0010, 32'h0);
    send_marker(OP_BEGIN, ADC_CHANNEL, 32'hFFFF_FFFF, 32'h0);
    send_marker(OP_END,   ADC_CHANNEL, 32'h0, 32'h5A5A_5A5A);
    send_marker(OP_BEGIN, 3'd7, 32'h5, 32'd123);
    send_marker(OP_END,   3'd7, 32'h0, 32'h0);
    send_marker(OP_BEGIN, SLOT_CHANNEL, 32'd1000, 32'hFFFF_FFFF);
    send_marker(OP_END,   SLOT_CHANNEL, 32'd990, 32'h0);
    send_marker(OP_BEGIN, 3'd2, 32'h0, 32'hA5A5_A5A5);
    send_marker(OP_END,   3'd2, 32'hFFFF_FFFF, 32'h0);
    send_marker(OP_BEGIN, ADC_CHANNEL, 32'd500, 32'hFFFF_FFFF);
    send_marker(OP_END,   ADC_CHANNEL, 32'd500, 32'h0);
    send_marker(OP_END,   3'd2, 32'h0, 32'h0);
    send_marker(OP_END,   SLOT_CHANNEL, 32'h0, 32'h0);
    send_marker(OP_BEGIN, 3'd1, 32'h8000_0000, 32'h0);
    send_marker(OP_BEGIN, 3'd4, 32'd7, 32'h0);
    send_marker(OP_BEGIN, 3'd5, 32'hFFFF_FFFF, 32'h0);
    send_marker(OP_END,   3'd5, 32'hFFFF_FFFE, 32'h0);
    send_marker(OP_END,   3'd4, 32'd8, 32'h0);
    send_marker(OP_END,   3'd1, 32'h0, 32'h0);
    send_marker(OP_BEGIN, ADC_CHANNEL, 32'd300, 32'hFFFF_FFFF);
    send_marker(OP_END,   ADC_CHANNEL, 32'd100, 32'h0);
    send_marker(OP_BEGIN, ADC_CHANNEL, 32'h0, 32'h0);
    send_marker(OP_END,   ADC_CHANNEL, 32'h1234_5678, 32'hFFFF_FFFF);

    for (int phase = 0; phase < 6; phase++) begin
      if (phase != 0) load_budget(budget_plan[phase]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 40) burst <= 1'b1;
        if (n == 80) burst <= 1'b0;
        random_marker();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("run covered %0d markers and %0d results over six budget settings",
             markers, results);
    $display("with %0d statistic clears and %0d over-budget runs", clears, overs);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
